[rtl/mpdc_pkg.sv]
package mpdc_pkg;

   localparam int PUMP_COUNT_DEFAULT = 4;
   localparam int PWM_BITS_DEFAULT = 10;
   localparam int CAL_REGS = 4;
   localparam int MAX_RESULTS = 4;

   localparam logic [9:0] DRIVE_DUTY_RESET = 10'd700;
   localparam logic [31:0] DEFAULT_TARGET = 32'd1000;
   localparam logic [18:0] TIMEOUT_RESET = 19'd30000;
   localparam logic [26:0] TIMEOUT_MIN = 27'd10000;
   localparam logic [26:0] TIMEOUT_MAX = 27'd300000;
   localparam logic [18:0] ELAPSED_MAX = 19'h7ffff;

   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_ENC_EDGE  = 3'd1,
      CMD_DOSE      = 3'd2,
      CMD_STOP      = 3'd3,
      CMD_SET_DUTY  = 3'd4,
      CMD_CLR_COUNT = 3'd5,
      CMD_QUERY     = 3'd6,
      CMD_STOP_ALL  = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_COMPLETED = 3'd1,
      EV_TIMEOUT   = 3'd2,
      EV_MANUAL    = 3'd3,
      EV_OVERRIDE  = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      CSR_CAL0  = 3'd0,
      CSR_CAL1  = 3'd1,
      CSR_CAL2  = 3'd2,
      CSR_CAL3  = 3'd3,
      CSR_DUTY  = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      DP_IDLE,
      DP_LATCH,
      DP_EVAL,
      DP_SCAN,
      DP_APPLY,
      DP_EMIT_SCAN,
      DP_EMIT_ONE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      last;
   } dp_cmd_type;

   typedef struct packed {
      logic is_scan;
      logic is_edge;
      logic in_range;
      logic slot_free;
      logic flag;
      logic more;
   } dp_sts_type;

endpackage

[rtl/mpdc_if.sv]
interface mpdc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [1:0]  pump;
   logic [23:0] dose_volume;
   logic [9:0]  duty;

   modport source (output valid, command, pump, dose_volume, duty, input ready);
   modport sink (input valid, command, pump, dose_volume, duty, output ready);
endinterface

interface mpdc_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         pump_index;
   logic [2:0]         stop_event;
   logic signed [31:0] pulses_done;
   logic               running;
   logic signed [31:0] pulse_count;
   logic [9:0]         pwm_compare;
   logic [47:0]        pulses_total;
   logic               last;

   modport source (output valid, pump_index, stop_event, pulses_done, running, pulse_count,
                   pwm_compare, pulses_total, last, input ready);
   modport sink (input valid, pump_index, stop_event, pulses_done, running, pulse_count,
                 pwm_compare, pulses_total, last, output ready);
endinterface

[rtl/mpdc_datapath.sv]
module mpdc_datapath #(
   parameter int PUMP_COUNT = 4,
   parameter int PWM_BITS = 10,
   parameter int IDX_W = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             req_command,
   input  logic [1:0]             req_pump,
   input  logic [23:0]            req_dose_volume,
   input  logic [9:0]             req_duty,
   input  logic                   csr_write_en,
   input  logic [2:0]             csr_index,
   input  logic [23:0]            csr_wdata,
   input  mpdc_pkg::dp_cmd_type   cmd,
   input  logic [IDX_W-1:0]       idx,
   output mpdc_pkg::dp_sts_type   sts,
   output logic [IDX_W-1:0]       pump_sel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_pump_index,
   output logic [2:0]             rsp_stop_event,
   output logic signed [31:0]     rsp_pulses_done,
   output logic                   rsp_running,
   output logic signed [31:0]     rsp_pulse_count,
   output logic [9:0]             rsp_pwm_compare,
   output logic [47:0]            rsp_pulses_total,
   output logic                   rsp_last
);
   import mpdc_pkg::*;

   localparam int CW = (PWM_BITS > 10) ? PWM_BITS : 10;
   localparam logic [PWM_BITS-1:0] PWM_MAX = '1;

   function automatic logic [PWM_BITS-1:0] to_compare(input logic [9:0] d);
      logic [CW-1:0] dx;
      logic [CW-1:0] mx;
      dx = CW'(d);
      mx = CW'(PWM_MAX);
      if (dx > mx) dx = mx;
      return PWM_BITS'(mx - dx);
   endfunction

   // configuration
   logic [23:0] cal_ff [CAL_REGS];
   logic [9:0]  drive_duty_ff;

   // latched item
   cmd_type     cmd_ff;
   logic [1:0]  pump_ff;
   logic [23:0] vol_ff;
   logic [9:0]  duty_ff;

   // per-pump state
   logic                job_active_ff [PUMP_COUNT];
   logic [31:0]         target_ff [PUMP_COUNT];
   logic [31:0]         start_ff [PUMP_COUNT];
   logic [18:0]         elapsed_ff [PUMP_COUNT];
   logic [18:0]         timeout_ff [PUMP_COUNT];
   logic [31:0]         enc_ff [PUMP_COUNT];
   logic                enc_en_ff [PUMP_COUNT];
   logic [PWM_BITS-1:0] compare_ff [PUMP_COUNT];
   logic [47:0]         total_ff [PUMP_COUNT];
   logic [PUMP_COUNT-1:0] flag_ff;
   logic [PUMP_COUNT-1:0] late_ff;

   // intermediate results
   logic [31:0] diff_ff;
   logic [47:0] prod_ff;
   logic [24:0] est_ff;
   logic        cal_zero_ff;
   event_type   ev_ff;
   logic [31:0] done_ff;

   // output register
   logic        rsp_valid_ff;
   logic [1:0]  o_pump_ff;
   logic [2:0]  o_event_ff;
   logic [31:0] o_done_ff;
   logic        o_running_ff;
   logic [31:0] o_count_ff;
   logic [9:0]  o_compare_ff;
   logic [47:0] o_total_ff;
   logic        o_last_ff;

   logic [IDX_W+1:0] pump_wide;
   logic [30:0]      vol_x125;
   logic [18:0]      elapsed_inc;
   logic             reached;
   logic             late;
   logic             diff_pos;
   logic [47:0]      total_add;
   logic [31:0]      target_new;
   logic [26:0]      tmo3;
   logic [18:0]      tmo_new;
   logic             more;
   logic [CW-1:0]    cmp_ext;
   logic [IDX_W+1:0] idx_wide;
   logic [31:0]      cur_diff;
   logic             is_scan;

   assign pump_wide = (IDX_W + 2)'(pump_ff);
   assign pump_sel = pump_wide[IDX_W-1:0];
   assign idx_wide = (IDX_W + 2)'(idx);
   assign is_scan = (cmd_ff == CMD_TICK) || (cmd_ff == CMD_STOP_ALL);

   always_comb begin
      vol_x125 = (31'(vol_ff) << 7) - (31'(vol_ff) << 2) + 31'(vol_ff);
      elapsed_inc = (elapsed_ff[idx] == ELAPSED_MAX) ? ELAPSED_MAX : elapsed_ff[idx] + 19'd1;
      reached = $signed(diff_ff) >= $signed(target_ff[idx]);
      late = elapsed_inc > timeout_ff[idx];
      diff_pos = !diff_ff[31] && (diff_ff != 32'd0);
      total_add = total_ff[idx] + 48'(diff_ff);
      if (cal_zero_ff) begin
         target_new = DEFAULT_TARGET;
      end else if (prod_ff[47]) begin
         target_new = 32'h7fff_ffff;
      end else begin
         target_new = prod_ff[47:16];
      end
      tmo3 = 27'(est_ff) + {1'b0, est_ff, 1'b0};
      if (tmo3 > TIMEOUT_MAX) begin
         tmo_new = 19'(TIMEOUT_MAX);
      end else if (tmo3 < TIMEOUT_MIN) begin
         tmo_new = 19'(TIMEOUT_MIN);
      end else begin
         tmo_new = tmo3[18:0];
      end
      more = 1'b0;
      for (int i = 0; i < PUMP_COUNT; i++) begin
         if ((i > int'(idx)) && flag_ff[i]) more = 1'b1;
      end
      cmp_ext = CW'(compare_ff[idx]);
      cur_diff = enc_ff[idx] - start_ff[idx];
   end

   always_comb begin
      sts.is_scan = is_scan;
      sts.is_edge = (cmd_ff == CMD_ENC_EDGE);
      sts.in_range = pump_wide < (IDX_W + 2)'(PUMP_COUNT);
      sts.slot_free = !rsp_valid_ff || rsp_ready;
      sts.flag = flag_ff[idx];
      sts.more = more;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAL_REGS; i++) cal_ff[i] <= '0;
         drive_duty_ff <= DRIVE_DUTY_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CAL0: cal_ff[0] <= csr_wdata;
            CSR_CAL1: cal_ff[1] <= csr_wdata;
            CSR_CAL2: cal_ff[2] <= csr_wdata;
            CSR_CAL3: cal_ff[3] <= csr_wdata;
            CSR_DUTY: drive_duty_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // item latch and intermediate values
   always_ff @(posedge clock) begin
      if (cmd.op == DP_LATCH) begin
         cmd_ff <= cmd_type'(req_command);
         pump_ff <= req_pump;
         vol_ff <= req_dose_volume;
         duty_ff <= req_duty;
      end
      if (cmd.op == DP_EVAL) begin
         diff_ff <= enc_ff[idx] - start_ff[idx];
         prod_ff <= 48'(vol_ff) * 48'(cal_ff[pump_ff]);
         cal_zero_ff <= (cal_ff[pump_ff] == 24'd0);
         est_ff <= vol_x125[30:6];
      end
   end

   // per-pump state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PUMP_COUNT; i++) begin
            job_active_ff[i] <= 1'b0;
            target_ff[i] <= '0;
            start_ff[i] <= '0;
            elapsed_ff[i] <= '0;
            timeout_ff[i] <= TIMEOUT_RESET;
            enc_ff[i] <= '0;
            enc_en_ff[i] <= 1'b0;
            compare_ff[i] <= PWM_MAX;
            total_ff[i] <= '0;
         end
         flag_ff <= '0;
         late_ff <= '0;
         ev_ff <= EV_NONE;
         done_ff <= '0;
      end else begin
         if (cmd.op == DP_SCAN) begin
            flag_ff[idx] <= 1'b0;
            late_ff[idx] <= 1'b0;
            if (cmd_ff == CMD_STOP_ALL) begin
               enc_en_ff[idx] <= 1'b0;
               compare_ff[idx] <= PWM_MAX;
               if (job_active_ff[idx]) begin
                  job_active_ff[idx] <= 1'b0;
                  flag_ff[idx] <= 1'b1;
                  if (diff_pos) total_ff[idx] <= total_add;
               end
            end else if (job_active_ff[idx]) begin
               elapsed_ff[idx] <= elapsed_inc;
               if (reached || late) begin
                  job_active_ff[idx] <= 1'b0;
                  enc_en_ff[idx] <= 1'b0;
                  compare_ff[idx] <= PWM_MAX;
                  flag_ff[idx] <= 1'b1;
                  late_ff[idx] <= late && !reached;
                  if (diff_pos) total_ff[idx] <= total_add;
               end
            end
         end
         if (cmd.op == DP_APPLY) begin
            ev_ff <= EV_NONE;
            done_ff <= '0;
            unique case (cmd_ff)
               CMD_ENC_EDGE: begin
                  if (enc_en_ff[idx]) enc_ff[idx] <= enc_ff[idx] + 32'd1;
               end
               CMD_DOSE: begin
                  if (vol_ff != 24'd0) begin
                     if (job_active_ff[idx]) begin
                        ev_ff <= EV_OVERRIDE;
                        done_ff <= diff_ff;
                        if (diff_pos) total_ff[idx] <= total_add;
                     end
                     target_ff[idx] <= target_new;
                     timeout_ff[idx] <= tmo_new;
                     job_active_ff[idx] <= 1'b1;
                     start_ff[idx] <= enc_ff[idx];
                     elapsed_ff[idx] <= '0;
                     enc_en_ff[idx] <= 1'b1;
                     compare_ff[idx] <= to_compare(drive_duty_ff);
                  end
               end
               CMD_STOP: begin
                  job_active_ff[idx] <= 1'b0;
                  enc_en_ff[idx] <= 1'b0;
                  compare_ff[idx] <= PWM_MAX;
                  if (job_active_ff[idx]) begin
                     ev_ff <= EV_MANUAL;
                     done_ff <= diff_ff;
                     if (diff_pos) total_ff[idx] <= total_add;
                  end
               end
               CMD_SET_DUTY: begin
                  if (duty_ff == 10'd0) begin
                     enc_en_ff[idx] <= 1'b0;
                     compare_ff[idx] <= PWM_MAX;
                  end else begin
                     enc_en_ff[idx] <= 1'b1;
                     compare_ff[idx] <= to_compare(duty_ff);
                  end
               end
               CMD_CLR_COUNT: enc_ff[idx] <= '0;
               default: ;
            endcase
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((cmd.op == DP_EMIT_SCAN) || (cmd.op == DP_EMIT_ONE)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.op == DP_EMIT_SCAN) || (cmd.op == DP_EMIT_ONE)) begin
         o_pump_ff <= idx_wide[1:0];
         o_running_ff <= job_active_ff[idx];
         o_count_ff <= enc_ff[idx];
         o_compare_ff <= cmp_ext[9:0];
         o_total_ff <= total_ff[idx];
         o_last_ff <= cmd.last;
         if (cmd.op == DP_EMIT_SCAN) begin
            o_done_ff <= cur_diff;
            if (cmd_ff == CMD_STOP_ALL) begin
               o_event_ff <= EV_MANUAL;
            end else begin
               o_event_ff <= late_ff[idx] ? EV_TIMEOUT : EV_COMPLETED;
            end
         end else begin
            o_done_ff <= done_ff;
            o_event_ff <= ev_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pump_index = o_pump_ff;
   assign rsp_stop_event = o_event_ff;
   assign rsp_pulses_done = $signed(o_done_ff);
   assign rsp_running = o_running_ff;
   assign rsp_pulse_count = $signed(o_count_ff);
   assign rsp_pwm_compare = o_compare_ff;
   assign rsp_pulses_total = o_total_ff;
   assign rsp_last = o_last_ff;

endmodule

[rtl/mpdc_ctrl.sv]
module mpdc_ctrl #(
   parameter int PUMP_COUNT = 4,
   parameter int IDX_W = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mpdc_pkg::dp_sts_type sts,
   input  logic [IDX_W-1:0]     pump_sel,
   output mpdc_pkg::dp_cmd_type cmd,
   output logic [IDX_W-1:0]     idx
);
   import mpdc_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PUMP_COUNT - 1);
   localparam logic [2:0] RES_LIMIT = 3'(MAX_RESULTS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN_EVAL,
      S_SCAN_APPLY,
      S_EMIT_SCAN,
      S_EVAL,
      S_APPLY,
      S_RESP
   } state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [2:0]       cnt_ff;
   logic             emit_ok;
   logic             emit_last;

   assign emit_ok = sts.flag && (cnt_ff < RES_LIMIT);
   assign emit_last = (cnt_ff == RES_LIMIT - 3'd1) || !sts.more;
   assign req_ready = (state_ff == S_IDLE);
   assign idx = idx_ff;

   always_comb begin
      cmd.op = DP_IDLE;
      cmd.last = 1'b0;
      unique case (state_ff)
         S_IDLE:       if (req_valid) cmd.op = DP_LATCH;
         S_SCAN_EVAL:  cmd.op = DP_EVAL;
         S_SCAN_APPLY: cmd.op = DP_SCAN;
         S_EVAL:       cmd.op = DP_EVAL;
         S_APPLY:      cmd.op = DP_APPLY;
         S_EMIT_SCAN: begin
            if (emit_ok && sts.slot_free) begin
               cmd.op = DP_EMIT_SCAN;
               cmd.last = emit_last;
            end
         end
         S_RESP: begin
            if (sts.slot_free) begin
               cmd.op = DP_EMIT_ONE;
               cmd.last = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         cnt_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_DISPATCH;
            S_DISPATCH: begin
               cnt_ff <= '0;
               if (sts.is_scan) begin
                  idx_ff <= '0;
                  state_ff <= S_SCAN_EVAL;
               end else if (!sts.in_range) begin
                  state_ff <= S_IDLE;
               end else begin
                  idx_ff <= pump_sel;
                  state_ff <= S_EVAL;
               end
            end
            S_SCAN_EVAL: state_ff <= S_SCAN_APPLY;
            S_SCAN_APPLY: begin
               if (idx_ff == LAST_IDX) begin
                  idx_ff <= '0;
                  state_ff <= S_EMIT_SCAN;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_SCAN_EVAL;
               end
            end
            S_EMIT_SCAN: begin
               if (emit_ok) begin
                  if (sts.slot_free) begin
                     cnt_ff <= cnt_ff + 3'd1;
                     if (emit_last || idx_ff == LAST_IDX) begin
                        state_ff <= S_IDLE;
                     end else begin
                        idx_ff <= idx_ff + 1'b1;
                     end
                  end
               end else if (idx_ff == LAST_IDX || cnt_ff >= RES_LIMIT) begin
                  state_ff <= S_IDLE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_EVAL: state_ff <= S_APPLY;
            S_APPLY: state_ff <= sts.is_edge ? S_IDLE : S_RESP;
            S_RESP: if (sts.slot_free) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/multi_pump_dose_controller_core.sv]
// Dose controller for a set of encoder-fed dosing pumps.
// req_ch carries one command item (tick, encoder edge, dose, stop, set duty,
// clear count, query, stop all); rsp_ch returns status items, the final one
// of each command marked by last. Both channels use valid/ready.
// A single-pump command is dispatched, evaluated and applied, then gives one
// status item; an encoder edge or a pump out of range gives none. A tick or
// stop all evaluates and applies each pump in turn, then walks the pumps again
// to report stopped jobs, one per cycle while the receiver keeps up, up to four.
// One command is in work at a time; the next is taken once the controller
// has gone back to idle, while the last result may still sit in the output
// register. A stalled receiver holds the output register and the report walk.
// Configuration registers are written on the csr port; the user must do it
// only while idle (not enforced). Reset (synchronous) stops all pumps, clears
// counters and totals, sets all timeouts to 30000 ms and the drive duty to 700.
module multi_pump_dose_controller_core #(
   parameter int PUMP_COUNT = mpdc_pkg::PUMP_COUNT_DEFAULT,
   parameter int PWM_BITS = mpdc_pkg::PWM_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   mpdc_req_if.sink     req_ch,
   mpdc_rsp_if.source   rsp_ch,
   input  logic         csr_write_en,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_wdata
);
   import mpdc_pkg::*;

   localparam int IDX_W = (PUMP_COUNT > 1) ? $clog2(PUMP_COUNT) : 1;

   dp_cmd_type       dp_cmd;
   dp_sts_type       dp_sts;
   logic [IDX_W-1:0] idx;
   logic [IDX_W-1:0] pump_sel;

   mpdc_ctrl #(
      .PUMP_COUNT (PUMP_COUNT),
      .IDX_W      (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (dp_sts),
      .pump_sel  (pump_sel),
      .cmd       (dp_cmd),
      .idx       (idx)
   );

   mpdc_datapath #(
      .PUMP_COUNT (PUMP_COUNT),
      .PWM_BITS   (PWM_BITS),
      .IDX_W      (IDX_W)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_ch.command),
      .req_pump         (req_ch.pump),
      .req_dose_volume  (req_ch.dose_volume),
      .req_duty         (req_ch.duty),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (dp_cmd),
      .idx              (idx),
      .sts              (dp_sts),
      .pump_sel         (pump_sel),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_pump_index   (rsp_ch.pump_index),
      .rsp_stop_event   (rsp_ch.stop_event),
      .rsp_pulses_done  (rsp_ch.pulses_done),
      .rsp_running      (rsp_ch.running),
      .rsp_pulse_count  (rsp_ch.pulse_count),
      .rsp_pwm_compare  (rsp_ch.pwm_compare),
      .rsp_pulses_total (rsp_ch.pulses_total),
      .rsp_last         (rsp_ch.last)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("controller took a second item while busy");

   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == DP_EMIT_SCAN || dp_cmd.op == DP_EMIT_ONE) |-> dp_sts.slot_free)
      else $error("result loaded over an untaken result");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> ($past(dp_cmd.op) == DP_EMIT_SCAN ||
                               $past(dp_cmd.op) == DP_EMIT_ONE))
      else $error("result appeared without an emit command");

endmodule
